// ===== sv/bfra_pkg.sv =====
`default_nettype none
package bfra_pkg;

    typedef enum logic [2:0] {
        KIND_CREATE  = 3'd0,
        KIND_DESTROY = 3'd1,
        KIND_ALLOC   = 3'd2,
        KIND_FREE    = 3'd3,
        KIND_QUERY   = 3'd4
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_HEAP   = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY  = 3'd2;
    localparam logic [2:0] ST_NO_FIT    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_OUTSIDE   = 3'd5;

    localparam logic [31:0] LEFTOVER_LIMIT = 32'h4000_0000;
    localparam logic [31:0] LOW_RANGE_TOP  = 32'h8000_0000;
    localparam logic [31:0] ROUND_LIMIT    = 32'hFFFF_FFE0;
    localparam logic [7:0]  ENTRY_NIL      = 8'hFF;
    localparam logic [3:0]  HEAP_NIL       = 4'hF;

    // gap evaluation result handed from the gap unit to the sequencer
    typedef struct packed {
        logic [31:0] avail;
        logic        fits;
        logic [31:0] leftover;
    } gap_t;

endpackage
`default_nettype wire

// ===== sv/bfra_gap.sv =====
`default_nettype none
// shared gap unit: two subtracts and two compares per walk step
module bfra_gap
(
    input  wire logic [31:0] gap_start,
    input  wire logic [31:0] gap_end,
    input  wire logic [31:0] size,
    input  wire logic [31:0] least,
    output bfra_pkg::gap_t   result
);
    logic [31:0] avail;
    logic [31:0] left;

    always_comb
    begin
        avail = gap_end - gap_start;
        left  = avail - size;
        result.avail    = avail;
        result.leftover = left;
        result.fits     = (avail >= size) && (left <= least);
    end
endmodule
`default_nettype wire

// ===== sv/best_fit_region_allocator.sv =====
`default_nettype none
// best-fit region allocator
// input channel: in_valid/in_stall carries one operation beat (kind, heap_id,
// region_low, region_high, block_addr, request_size); the block raises
// in_stall from the accepted beat until its result beat has been taken
// output channel: out_valid/out_stall carries one result beat per operation
// (status, value, live_blocks, peak_blocks); the result is held while
// out_stall is high
// create and errors return without a list walk; destroy, free, query and
// allocate walk the heap's block list one descriptor per cycle through a
// single descriptor memory read port and a shared gap unit; the next input
// beat is taken only after the result beat has been taken; one operation
// is in flight at once
// configuration: cfg_we/cfg_index/cfg_data write arena_low (0), arena_high (1);
// the user must write them only while idle, the block itself does not enforce it
// reset: after rst_n rises a clearing pass chains the spare descriptor links,
// during which no beat is accepted; heap slots, counts and arena bounds reset
// at once
module best_fit_region_allocator #(
    parameter int ENTRIES = 128,
    parameter int HEAPS   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [2:0]  heap_id,
    input  wire logic [31:0] region_low,
    input  wire logic [31:0] region_high,
    input  wire logic [31:0] block_addr,
    input  wire logic [31:0] request_size,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [2:0]  status,
    output      logic [31:0] value,
    output      logic [7:0]  live_blocks,
    output      logic [7:0]  peak_blocks
);
    localparam int EW = $clog2(ENTRIES);
    localparam int HW = (HEAPS > 1) ? $clog2(HEAPS) : 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_READ, S_STEP, S_LINK, S_FIX, S_DONE
    } state_t;

    // descriptor memories, single read port registered
    logic [31:0] mem_addr [ENTRIES];
    logic [31:0] mem_size [ENTRIES];
    logic [7:0]  mem_link [ENTRIES];
    logic [31:0] rd_addr_reg, rd_size_reg;
    logic [7:0]  rd_link_reg;

    logic [31:0] heap_low_reg [HEAPS];
    logic [31:0] heap_high_reg [HEAPS];
    logic [7:0]  heap_first_reg [HEAPS];
    logic [3:0]  heap_link_reg [HEAPS];
    logic [HEAPS-1:0] heap_live_reg;
    logic [3:0]  spare_heap_reg;
    logic [7:0]  spare_entry_reg;
    logic [7:0]  live_reg, peak_reg;
    logic [31:0] arena_low_reg, arena_high_reg;

    state_t      state_reg;
    logic [7:0]  init_reg;
    logic [2:0]  kind_reg;
    logic [HW-1:0] h_reg;
    logic [31:0] baddr_reg, size_reg, start_reg, least_reg, lo_reg, sum_reg;
    logic [7:0]  cur_reg, prev_reg, best_prev_reg, e_reg;
    logic [7:0]  e_link_reg;
    logic        found_reg;

    // memory access control
    logic        mwe;
    logic [7:0]  mwa;
    logic [31:0] mwaddr, mwsize;
    logic [7:0]  mwlink;
    logic        lwe_only;
    logic [7:0]  mra;

    logic        cur_nil;
    logic [31:0] gap_end;
    bfra_pkg::gap_t gap;

    assign cur_nil = (cur_reg >= 8'(ENTRIES));
    assign gap_end = cur_nil ? heap_high_reg[h_reg] : rd_addr_reg;

    bfra_gap u_gap (
        .gap_start (start_reg),
        .gap_end   (gap_end),
        .size      (size_reg),
        .least     (least_reg),
        .result    (gap)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign live_blocks = live_reg;
    assign peak_blocks = peak_reg;

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            if (!lwe_only)
            begin
                mem_addr[mwa[EW-1:0]] <= mwaddr;
                mem_size[mwa[EW-1:0]] <= mwsize;
            end
            mem_link[mwa[EW-1:0]] <= mwlink;
        end
        rd_addr_reg <= mem_addr[mra[EW-1:0]];
        rd_size_reg <= mem_size[mra[EW-1:0]];
        rd_link_reg <= mem_link[mra[EW-1:0]];
    end

    function automatic logic [7:0] ent_ok(input logic [7:0] e);
        ent_ok = (e < 8'(ENTRIES)) ? e : bfra_pkg::ENTRY_NIL;
    endfunction

    // memory port steering
    always_comb
    begin
        mwe = 1'b0; lwe_only = 1'b1; mwa = '0; mwaddr = '0; mwsize = '0;
        mwlink = '0; mra = cur_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mwe = 1'b1; mwa = init_reg;
                mwlink = (init_reg + 8'd1 < 8'(ENTRIES)) ? init_reg + 8'd1
                                                          : bfra_pkg::ENTRY_NIL;
            end
            S_LINK:
            begin
                mra = best_prev_reg;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_STEP && !cur_nil)
            mra = ent_ok(rd_link_reg);
        if (state_reg == S_STEP && !cur_nil && kind_reg == bfra_pkg::KIND_DESTROY)
        begin
            mwe = 1'b1; mwa = cur_reg; mwlink = spare_entry_reg;
        end
        if (state_reg == S_STEP && !cur_nil && kind_reg == bfra_pkg::KIND_FREE
            && rd_addr_reg == baddr_reg && prev_reg != bfra_pkg::ENTRY_NIL)
        begin
            mwe = 1'b1; mwa = prev_reg; mwlink = rd_link_reg;
        end
        if (state_reg == S_FIX && kind_reg == bfra_pkg::KIND_FREE)
        begin
            // freed descriptor goes on top of the spare chain
            mwe = 1'b1; mwa = cur_reg; mwlink = e_reg;
        end
        else if (state_reg == S_FIX)
        begin
            mwe = 1'b1; mwa = e_reg; lwe_only = 1'b0;
            mwaddr = lo_reg; mwsize = size_reg;
            mwlink = (best_prev_reg == bfra_pkg::ENTRY_NIL) ? heap_first_reg[h_reg]
                                                             : rd_link_reg;
        end
        if (state_reg == S_DONE && kind_reg == bfra_pkg::KIND_ALLOC && found_reg
            && best_prev_reg != bfra_pkg::ENTRY_NIL && !out_valid)
        begin
            mwe = 1'b1; mwa = best_prev_reg; mwlink = e_reg;
        end
        if (state_reg == S_STEP && !cur_nil && kind_reg == bfra_pkg::KIND_FREE
            && rd_addr_reg == baddr_reg)
            mra = cur_reg;
        if (state_reg == S_DECODE && kind_reg == bfra_pkg::KIND_ALLOC)
            mra = spare_entry_reg;
    end

    logic [7:0] live_inc;
    assign live_inc = live_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg <= '0;
            out_valid <= 1'b0;
            status <= '0;
            value <= '0;
            spare_heap_reg <= '0;
            spare_entry_reg <= '0;
            heap_live_reg <= '0;
            live_reg <= '0;
            peak_reg <= '0;
            arena_low_reg <= '0;
            arena_high_reg <= 32'h0100_0000;
            for (int i = 0; i < HEAPS; i++)
            begin
                heap_first_reg[i] <= bfra_pkg::ENTRY_NIL;
                heap_link_reg[i] <= (i + 1 < HEAPS) ? 4'(i + 1) : bfra_pkg::HEAP_NIL;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    arena_low_reg <= cfg_data;
                else
                    arena_high_reg <= cfg_data;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 8'd1;
                    if (init_reg == 8'(ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        h_reg     <= HW'(heap_id);
                        baddr_reg <= block_addr;
                        status    <= bfra_pkg::ST_OK;
                        value     <= '0;
                        start_reg <= region_low;
                        lo_reg    <= region_high;
                        size_reg  <= request_size;
                        state_reg <= S_DECODE;
                        if (kind != bfra_pkg::KIND_CREATE
                            && (32'(heap_id) >= 32'(HEAPS)))
                        begin
                            status <= bfra_pkg::ST_NOT_FOUND;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DECODE:
                begin
                    cur_reg   <= ent_ok(heap_first_reg[h_reg]);
                    prev_reg  <= bfra_pkg::ENTRY_NIL;
                    best_prev_reg <= bfra_pkg::ENTRY_NIL;
                    least_reg <= bfra_pkg::LEFTOVER_LIMIT;
                    found_reg <= 1'b0;
                    sum_reg   <= '0;
                    e_reg     <= spare_entry_reg;
                    state_reg <= S_READ;
                    if (kind_reg == bfra_pkg::KIND_CREATE)
                    begin
                        state_reg <= S_DONE;
                        if (spare_heap_reg >= 4'(HEAPS))
                            status <= bfra_pkg::ST_NO_HEAP;
                        else if (start_reg < bfra_pkg::LOW_RANGE_TOP
                                 && lo_reg < bfra_pkg::LOW_RANGE_TOP
                                 && !(start_reg >= arena_low_reg
                                      && lo_reg <= arena_high_reg))
                            status <= bfra_pkg::ST_OUTSIDE;
                        else
                        begin
                            spare_heap_reg <= heap_link_reg[spare_heap_reg[HW-1:0]];
                            heap_link_reg[spare_heap_reg[HW-1:0]] <= bfra_pkg::HEAP_NIL;
                            heap_low_reg[spare_heap_reg[HW-1:0]] <= start_reg;
                            heap_high_reg[spare_heap_reg[HW-1:0]] <= lo_reg;
                            heap_first_reg[spare_heap_reg[HW-1:0]] <= bfra_pkg::ENTRY_NIL;
                            heap_live_reg[spare_heap_reg[HW-1:0]] <= 1'b1;
                            value <= 32'(spare_heap_reg);
                        end
                    end
                    else if (kind_reg > bfra_pkg::KIND_QUERY || !heap_live_reg[h_reg])
                    begin
                        status <= bfra_pkg::ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        start_reg <= heap_low_reg[h_reg];
                        if (kind_reg == bfra_pkg::KIND_FREE)
                            status <= bfra_pkg::ST_NOT_FOUND;
                        if (kind_reg == bfra_pkg::KIND_ALLOC)
                        begin
                            if (spare_entry_reg >= 8'(ENTRIES))
                            begin
                                status <= bfra_pkg::ST_NO_ENTRY;
                                state_reg <= S_DONE;
                            end
                            else if (size_reg > bfra_pkg::ROUND_LIMIT)
                            begin
                                status <= bfra_pkg::ST_NO_FIT;
                                state_reg <= S_DONE;
                            end
                            else
                                size_reg <= (size_reg + 32'd31) & ~32'd31;
                        end
                    end
                end
                S_READ:
                begin
                    // spare head link is in the read register, cur's read is issued
                    if (kind_reg == bfra_pkg::KIND_ALLOC)
                        e_link_reg <= rd_link_reg;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    // one list element per cycle
                    cur_reg <= ent_ok(rd_link_reg);
                    prev_reg <= cur_reg;
                    start_reg <= rd_addr_reg + rd_size_reg;
                    unique case (kind_reg)
                        bfra_pkg::KIND_DESTROY:
                        begin
                            if (cur_nil)
                            begin
                                heap_first_reg[h_reg] <= bfra_pkg::ENTRY_NIL;
                                heap_live_reg[h_reg] <= 1'b0;
                                heap_link_reg[h_reg] <= spare_heap_reg;
                                spare_heap_reg <= 4'(h_reg);
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                spare_entry_reg <= cur_reg;
                                live_reg <= live_reg - 8'd1;
                            end
                        end
                        bfra_pkg::KIND_FREE:
                        begin
                            if (cur_nil)
                                state_reg <= S_DONE;
                            else if (rd_addr_reg == baddr_reg)
                            begin
                                if (prev_reg == bfra_pkg::ENTRY_NIL)
                                    heap_first_reg[h_reg] <= rd_link_reg;
                                state_reg <= S_LINK;
                                status <= bfra_pkg::ST_OK;
                                cur_reg <= cur_reg;
                                live_reg <= live_reg - 8'd1;
                            end
                        end
                        bfra_pkg::KIND_QUERY:
                        begin
                            sum_reg <= sum_reg + gap.avail;
                            if (cur_nil)
                            begin
                                value <= sum_reg + gap.avail;
                                state_reg <= S_DONE;
                            end
                        end
                        default:
                        begin
                            if (gap.fits)
                            begin
                                least_reg <= gap.leftover;
                                lo_reg <= start_reg;
                                best_prev_reg <= prev_reg;
                                found_reg <= 1'b1;
                            end
                            if (cur_nil)
                            begin
                                if (gap.fits || found_reg)
                                    state_reg <= S_LINK;
                                else
                                begin
                                    status <= bfra_pkg::ST_NO_FIT;
                                    state_reg <= S_DONE;
                                end
                            end
                        end
                    endcase
                end
                S_LINK:
                begin
                    // free: return entry to spare chain; alloc: read best_prev link
                    if (kind_reg == bfra_pkg::KIND_FREE)
                    begin
                        spare_entry_reg <= cur_reg;
                        state_reg <= S_FIX;
                    end
                    else
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    if (kind_reg == bfra_pkg::KIND_FREE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        spare_entry_reg <= e_link_reg;
                        if (best_prev_reg == bfra_pkg::ENTRY_NIL)
                            heap_first_reg[h_reg] <= e_reg;
                        live_reg <= live_inc;
                        if (live_inc > peak_reg)
                            peak_reg <= live_inc;
                        value <= lo_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid)
                        out_valid <= 1'b1;
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_best_fit_region_allocator.sv =====
`default_nettype none
module tb_best_fit_region_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 128;
    localparam int NUM_HEAPS   = 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PER_PHASE = 325;

    // one operation beat as it goes into the block
    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  heap_id;
        logic [31:0] region_low;
        logic [31:0] region_high;
        logic [31:0] block_addr;
        logic [31:0] request_size;
    } op_t;

    // one result beat as it should come out
    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  live_blocks;
        logic [7:0]  peak_blocks;
    } res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [2:0]  heap_id = '0;
    logic [31:0] region_low = '0;
    logic [31:0] region_high = '0;
    logic [31:0] block_addr = '0;
    logic [31:0] request_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] value;
    logic [7:0]  live_blocks;
    logic [7:0]  peak_blocks;

    best_fit_region_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .heap_id      (heap_id),
        .region_low   (region_low),
        .region_high  (region_high),
        .block_addr   (block_addr),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value        (value),
        .live_blocks  (live_blocks),
        .peak_blocks  (peak_blocks)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow copy of the allocator state
    // ---------------------------------------------------------------
    logic [31:0] blk_addr_mem [NUM_ENTRIES];
    logic [31:0] blk_size_mem [NUM_ENTRIES];
    logic [7:0]  blk_link_mem [NUM_ENTRIES];
    logic [7:0]  spare_blk;
    logic [31:0] heap_lo_mem [NUM_HEAPS];
    logic [31:0] heap_hi_mem [NUM_HEAPS];
    logic [7:0]  heap_head_mem [NUM_HEAPS];
    logic [3:0]  heap_next_mem [NUM_HEAPS];
    logic [3:0]  spare_heap;
    bit          heap_alive [NUM_HEAPS];
    logic [7:0]  live_cnt;
    logic [7:0]  peak_cnt;
    logic [31:0] arena_lo;
    logic [31:0] arena_hi;

    op_t  pending_ops [$];
    res_t expected_results [$];
    op_t  cur_op;
    int   errors = 0;
    int   cycles = 0;
    bit   hold_off = 1'b0;
    bit   no_idle = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic void reset_shadow();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            blk_addr_mem[i] = '0;
            blk_size_mem[i] = '0;
            blk_link_mem[i] = (i + 1 < NUM_ENTRIES) ? 8'(i + 1) : bfra_pkg::ENTRY_NIL;
        end
        spare_blk = '0;
        for (int i = 0; i < NUM_HEAPS; i++)
        begin
            heap_lo_mem[i] = '0;
            heap_hi_mem[i] = '0;
            heap_head_mem[i] = bfra_pkg::ENTRY_NIL;
            heap_next_mem[i] = (i + 1 < NUM_HEAPS) ? 4'(i + 1) : bfra_pkg::HEAP_NIL;
            heap_alive[i] = 1'b0;
        end
        spare_heap = '0;
        live_cnt = '0;
        peak_cnt = '0;
        arena_lo = '0;
        arena_hi = 32'h0100_0000;
    endfunction

    function automatic void return_block(int e);
        blk_link_mem[e] = spare_blk;
        spare_blk = 8'(e);
        live_cnt = live_cnt - 8'd1;
    endfunction

    // works out the result of one operation and advances the shadow state
    function automatic res_t allocator_outcome(op_t op);
        res_t r;
        int h;
        int s;
        int e;
        int cur;
        int nx;
        int prev;
        int best_prev;
        logic [31:0] size;
        logic [31:0] start;
        logic [31:0] fin;
        logic [31:0] avail;
        logic [31:0] least;
        logic [31:0] lo;
        logic [31:0] sum;
        bit found;
        r.status = bfra_pkg::ST_OK;
        r.value = '0;
        h = int'(op.heap_id);
        lo = '0;
        if (op.kind == bfra_pkg::KIND_CREATE)
        begin
            s = int'(spare_heap);
            if (s >= NUM_HEAPS)
                r.status = bfra_pkg::ST_NO_HEAP;
            else if (op.region_low < bfra_pkg::LOW_RANGE_TOP
                     && op.region_high < bfra_pkg::LOW_RANGE_TOP
                     && !(op.region_low >= arena_lo && op.region_high <= arena_hi))
                r.status = bfra_pkg::ST_OUTSIDE;
            else
            begin
                spare_heap = heap_next_mem[s];
                heap_next_mem[s] = bfra_pkg::HEAP_NIL;
                heap_lo_mem[s] = op.region_low;
                heap_hi_mem[s] = op.region_high;
                heap_head_mem[s] = bfra_pkg::ENTRY_NIL;
                heap_alive[s] = 1'b1;
                r.value = 32'(s);
            end
        end
        else if (op.kind > bfra_pkg::KIND_QUERY || !heap_alive[h])
            r.status = bfra_pkg::ST_NOT_FOUND;
        else if (op.kind == bfra_pkg::KIND_DESTROY)
        begin
            cur = int'(heap_head_mem[h]);
            while (cur != bfra_pkg::ENTRY_NIL)
            begin
                nx = int'(blk_link_mem[cur]);
                return_block(cur);
                cur = nx;
            end
            heap_head_mem[h] = bfra_pkg::ENTRY_NIL;
            heap_alive[h] = 1'b0;
            heap_next_mem[h] = spare_heap;
            spare_heap = 4'(h);
        end
        else if (op.kind == bfra_pkg::KIND_ALLOC)
        begin
            e = int'(spare_blk);
            if (e >= NUM_ENTRIES)
                r.status = bfra_pkg::ST_NO_ENTRY;
            else if (op.request_size > bfra_pkg::ROUND_LIMIT)
                r.status = bfra_pkg::ST_NO_FIT;
            else
            begin
                size = (op.request_size + 32'd31) & ~32'd31;
                start = heap_lo_mem[h];
                least = bfra_pkg::LEFTOVER_LIMIT;
                prev = bfra_pkg::ENTRY_NIL;
                best_prev = bfra_pkg::ENTRY_NIL;
                cur = int'(heap_head_mem[h]);
                found = 1'b0;
                // every gap, including before the first and after the last block
                while (1)
                begin
                    fin = (cur != bfra_pkg::ENTRY_NIL) ? blk_addr_mem[cur] : heap_hi_mem[h];
                    avail = fin - start;
                    // later gap wins a tie
                    if (avail >= size && avail - size <= least)
                    begin
                        least = avail - size;
                        lo = start;
                        best_prev = prev;
                        found = 1'b1;
                    end
                    if (cur == bfra_pkg::ENTRY_NIL)
                        break;
                    start = blk_addr_mem[cur] + blk_size_mem[cur];
                    prev = cur;
                    cur = int'(blk_link_mem[cur]);
                end
                if (!found)
                    r.status = bfra_pkg::ST_NO_FIT;
                else
                begin
                    spare_blk = blk_link_mem[e];
                    blk_size_mem[e] = size;
                    blk_addr_mem[e] = lo;
                    if (best_prev == bfra_pkg::ENTRY_NIL)
                    begin
                        blk_link_mem[e] = heap_head_mem[h];
                        heap_head_mem[h] = 8'(e);
                    end
                    else
                    begin
                        blk_link_mem[e] = blk_link_mem[best_prev];
                        blk_link_mem[best_prev] = 8'(e);
                    end
                    live_cnt = live_cnt + 8'd1;
                    if (live_cnt > peak_cnt)
                        peak_cnt = live_cnt;
                    r.value = lo;
                end
            end
        end
        else if (op.kind == bfra_pkg::KIND_FREE)
        begin
            prev = bfra_pkg::ENTRY_NIL;
            cur = int'(heap_head_mem[h]);
            r.status = bfra_pkg::ST_NOT_FOUND;
            while (cur != bfra_pkg::ENTRY_NIL)
            begin
                if (blk_addr_mem[cur] == op.block_addr)
                begin
                    if (prev == bfra_pkg::ENTRY_NIL)
                        heap_head_mem[h] = blk_link_mem[cur];
                    else
                        blk_link_mem[prev] = blk_link_mem[cur];
                    return_block(cur);
                    r.status = bfra_pkg::ST_OK;
                    break;
                end
                prev = cur;
                cur = int'(blk_link_mem[cur]);
            end
        end
        else
        begin
            start = heap_lo_mem[h];
            sum = '0;
            cur = int'(heap_head_mem[h]);
            while (1)
            begin
                fin = (cur != bfra_pkg::ENTRY_NIL) ? blk_addr_mem[cur] : heap_hi_mem[h];
                sum = sum + (fin - start);
                if (cur == bfra_pkg::ENTRY_NIL)
                    break;
                start = blk_addr_mem[cur] + blk_size_mem[cur];
                cur = int'(blk_link_mem[cur]);
            end
            r.value = sum;
        end
        r.live_blocks = live_cnt;
        r.peak_blocks = peak_cnt;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: one op beat at a time from pending_ops, random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        op_t op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            // the prediction is taken at the moment the beat is accepted
            if (in_valid && !in_stall)
                expected_results.push_back(allocator_outcome(cur_op));
            if (in_valid && in_stall)
                ;   // stalled beat holds its payload
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!hold_off && pending_ops.size() != 0)
            begin
                op = pending_ops.pop_front();
                cur_op <= op;
                kind <= op.kind;
                heap_id <= op.heap_id;
                region_low <= op.region_low;
                region_high <= op.region_high;
                block_addr <= op.block_addr;
                request_size <= op.request_size;
                in_valid <= 1'b1;
                send_gap <= no_idle ? 0 : $urandom_range(0, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks every result beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t want;
        int n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected beat, value", value, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (value !== want.value)
                        report_mismatch("value", value, want.value);
                    if (live_blocks !== want.live_blocks)
                        report_mismatch("live_blocks", 32'(live_blocks), 32'(want.live_blocks));
                    if (peak_blocks !== want.peak_blocks)
                        report_mismatch("peak_blocks", 32'(peak_blocks), 32'(want.peak_blocks));
                end
                n = no_idle ? 0 : $urandom_range(0, 6);
                stall_left <= n;
                out_stall <= (n != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic op_t make_op(logic [2:0] k, int h, logic [31:0] rlo,
                                    logic [31:0] rhi, logic [31:0] addr,
                                    logic [31:0] req);
        op_t op;
        op.kind = k;
        op.heap_id = 3'(h);
        op.region_low = rlo;
        op.region_high = rhi;
        op.block_addr = addr;
        op.request_size = req;
        return op;
    endfunction

    // picks a live heap most of the time
    function automatic int pick_heap();
        int alive [$];
        for (int i = 0; i < NUM_HEAPS; i++)
            if (heap_alive[i])
                alive.push_back(i);
        if (alive.size() != 0 && $urandom_range(0, 99) < 88)
            return alive[$urandom_range(0, alive.size() - 1)];
        return $urandom_range(0, NUM_HEAPS - 1);
    endfunction

    // address of some block in the heap, or noise when it is empty and now and then otherwise
    function automatic logic [31:0] pick_block(int h);
        int cnt;
        int idx;
        int cur;
        cnt = 0;
        cur = int'(heap_head_mem[h]);
        while (heap_alive[h] && cur != bfra_pkg::ENTRY_NIL)
        begin
            cnt++;
            cur = int'(blk_link_mem[cur]);
        end
        if (cnt == 0 || $urandom_range(0, 9) == 0)
            return $urandom();
        idx = $urandom_range(0, cnt - 1);
        cur = int'(heap_head_mem[h]);
        for (int i = 0; i < idx; i++)
            cur = int'(blk_link_mem[cur]);
        return blk_addr_mem[cur];
    endfunction

    // a region that passes the arena check where possible, with random noise now and then
    function automatic op_t make_create();
        logic [31:0] span;
        logic [31:0] size;
        logic [31:0] base;
        if ($urandom_range(0, 9) == 0)
            return make_op(bfra_pkg::KIND_CREATE, 0, $urandom(), $urandom(), $urandom(),
                           $urandom());
        size = $urandom_range(512, 65536);
        span = arena_hi - arena_lo;
        if (arena_hi > arena_lo && span > size && arena_lo < bfra_pkg::LOW_RANGE_TOP &&
            $urandom_range(0, 3) != 0)
        begin
            base = arena_lo + ($urandom() % (span - size));
            if (base + size >= bfra_pkg::LOW_RANGE_TOP)
                base = arena_lo;
        end
        else
            base = bfra_pkg::LOW_RANGE_TOP | 32'($urandom_range(0, 32'h7F00_0000));
        return make_op(bfra_pkg::KIND_CREATE, $urandom_range(0, 7), base, base + size,
                       $urandom(), $urandom());
    endfunction

    function automatic op_t make_random_op();
        int roll;
        int h;
        logic [31:0] req;
        roll = $urandom_range(0, 99);
        h = pick_heap();
        req = ($urandom_range(0, 19) == 0) ? $urandom() : 32'($urandom_range(0, 2048));
        if (roll < 10)
            return make_create();
        else if (roll < 14)
            return make_op(bfra_pkg::KIND_DESTROY, h, $urandom(), $urandom(), $urandom(),
                           $urandom());
        else if (roll < 48)
            return make_op(bfra_pkg::KIND_ALLOC, h, $urandom(), $urandom(), $urandom(), req);
        else if (roll < 78)
            return make_op(bfra_pkg::KIND_FREE, h, $urandom(), $urandom(), pick_block(h),
                           $urandom());
        else if (roll < 92)
            return make_op(bfra_pkg::KIND_QUERY, h, $urandom(), $urandom(), $urandom(),
                           $urandom());
        // noise, unknown kinds among it
        return make_op(3'($urandom_range(0, 7)), $urandom_range(0, 7), $urandom(),
                       $urandom(), $urandom(), $urandom());
    endfunction

    // queue one op, generated against the state as it stands now
    task automatic send_op(op_t op);
        pending_ops.push_back(op);
        while (pending_ops.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_arena(logic [31:0] lo_val, logic [31:0] hi_val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data <= lo_val;
        @(posedge clk);
        cfg_index <= 1'b1;
        cfg_data <= hi_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        arena_lo = lo_val;
        arena_hi = hi_val;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [31:0] phase_lo [4];
        logic [31:0] phase_hi [4];
        int h;
        reset_shadow();
        phase_lo = '{32'h0000_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        phase_hi = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_arena(phase_lo[p], phase_hi[p]);
            no_idle = (p == 1);

            if (p == 0)
            begin
                // region right at the arena bounds, a high region, one just outside
                send_op(make_op(bfra_pkg::KIND_CREATE, 0, 32'h0, 32'h0100_0000, 0, 0));
                send_op(make_op(bfra_pkg::KIND_CREATE, 0, 32'h8000_0000, 32'hFFFF_FFFF,
                                0, 0));
                send_op(make_op(bfra_pkg::KIND_CREATE, 0, 32'h0, 32'h0100_0001, 0, 0));
                // reversed region, gaps wrap
                send_op(make_op(bfra_pkg::KIND_CREATE, 0, 32'h9000_0000, 32'h8000_0000,
                                0, 0));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 0, 0, 0, 0, 32'h0));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 0, 0, 0, 0, 32'h1));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 0, 0, 0, 0, bfra_pkg::ROUND_LIMIT));
                // rounding overflow
                send_op(make_op(bfra_pkg::KIND_ALLOC, 0, 0, 0, 0, 32'hFFFF_FFE1));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 0, 0, 0, 0, 32'hFFFF_FFFF));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 1, 0, 0, 0, 32'h4000_0000));
                // leftover above the limit is never taken
                send_op(make_op(bfra_pkg::KIND_ALLOC, 1, 0, 0, 0, 32'd32));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 2, 0, 0, 0, 32'd32));
                send_op(make_op(bfra_pkg::KIND_FREE, 0, 0, 0, 32'h0001_2345, 0));
                send_op(make_op(bfra_pkg::KIND_FREE, 0, 0, 0, 32'h0, 0));
                send_op(make_op(bfra_pkg::KIND_QUERY, 0, 0, 0, 0, 0));
                send_op(make_op(bfra_pkg::KIND_QUERY, 2, 0, 0, 0, 0));
                for (int k = 5; k < 8; k++)
                    send_op(make_op(3'(k), 0, $urandom(), $urandom(), $urandom(), $urandom()));
                // dead heap
                send_op(make_op(bfra_pkg::KIND_DESTROY, 1, 0, 0, 0, 0));
                send_op(make_op(bfra_pkg::KIND_ALLOC, 1, 0, 0, 0, 32'd64));
                send_op(make_op(bfra_pkg::KIND_QUERY, 1, 0, 0, 0, 0));
                // run out of heap slots
                for (int i = 0; i < 7; i++)
                    send_op(make_op(bfra_pkg::KIND_CREATE, 0, 32'h00A0_0000, 32'h00B0_0000,
                                    0, 0));
            end

            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // once per phase: a burst of allocations to use up descriptors
                if (i == RANDOM_PER_PHASE / 3)
                begin
                    h = pick_heap();
                    for (int j = 0; j < 130; j++)
                        send_op(make_op(bfra_pkg::KIND_ALLOC, h, 0, 0, 0,
                                        $urandom_range(0, 40)));
                end
                // sender holds off until the block has fully drained
                if (i == RANDOM_PER_PHASE / 2)
                begin
                    hold_off = 1'b1;
                    while (in_valid || expected_results.size() != 0)
                        @(posedge clk);
                    hold_off = 1'b0;
                end
                send_op(make_random_op());
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
